[hdl/wfc_pkg.sv]
// Shared types, constants and microcode for the wheel force controller.
`timescale 1ns / 1ps
`default_nettype none

package wfc_pkg;

    localparam int VAL_W     = 64;
    localparam int CFG_W     = 31;
    localparam int FLD_W     = 32;
    localparam int APB_AW    = 5;
    localparam int MUL_STEPS = 64;
    localparam int CNT_W     = $clog2(MUL_STEPS);
    localparam int UC_LEN    = 55;
    localparam int PC_W      = $clog2(UC_LEN);
    localparam int RF_DEPTH  = 32;
    localparam int RF_AW     = $clog2(RF_DEPTH);
    localparam int SRC_W     = RF_AW + 1;

    localparam logic [VAL_W-1:0] STEP_Q32 = 64'd429497;

    localparam logic [2:0] REG_FORCE_GAIN     = 3'd0;
    localparam logic [2:0] REG_TORQUE_CONST   = 3'd1;
    localparam logic [2:0] REG_NOM_INERTIA    = 3'd2;
    localparam logic [2:0] REG_WHEEL_RADIUS   = 3'd3;
    localparam logic [2:0] REG_HALF_TRACK     = 3'd4;
    localparam logic [2:0] REG_WHEEL_FRICTION = 3'd5;
    localparam logic [2:0] REG_OBS_CUTOFF     = 3'd6;
    localparam logic [2:0] REG_FOBS_CUTOFF    = 3'd7;

    // Register file entries
    localparam logic [SRC_W-1:0] R_IDL  = SRC_W'(0);
    localparam logic [SRC_W-1:0] R_IDR  = SRC_W'(1);
    localparam logic [SRC_W-1:0] R_IRL  = SRC_W'(2);
    localparam logic [SRC_W-1:0] R_IRR  = SRC_W'(3);
    localparam logic [SRC_W-1:0] R_IF   = SRC_W'(4);
    localparam logic [SRC_W-1:0] R_CL   = SRC_W'(5);
    localparam logic [SRC_W-1:0] R_CR   = SRC_W'(6);
    localparam logic [SRC_W-1:0] R_JG   = SRC_W'(7);
    localparam logic [SRC_W-1:0] R_KS   = SRC_W'(8);
    localparam logic [SRC_W-1:0] R_KFS  = SRC_W'(9);
    localparam logic [SRC_W-1:0] R_P    = SRC_W'(10);
    localparam logic [SRC_W-1:0] R_KI   = SRC_W'(11);
    localparam logic [SRC_W-1:0] R_DW   = SRC_W'(12);
    localparam logic [SRC_W-1:0] R_DOBL = SRC_W'(13);
    localparam logic [SRC_W-1:0] R_DOBR = SRC_W'(14);
    localparam logic [SRC_W-1:0] R_RTL  = SRC_W'(15);
    localparam logic [SRC_W-1:0] R_RTR  = SRC_W'(16);
    localparam logic [SRC_W-1:0] R_T1   = SRC_W'(17);
    localparam logic [SRC_W-1:0] R_T2   = SRC_W'(18);
    localparam logic [SRC_W-1:0] R_M    = SRC_W'(19);
    localparam logic [SRC_W-1:0] R_FRES = SRC_W'(20);
    localparam logic [SRC_W-1:0] R_RT   = SRC_W'(21);
    localparam logic [SRC_W-1:0] R_A    = SRC_W'(22);
    localparam logic [SRC_W-1:0] R_B    = SRC_W'(23);

    // Fixed operand sources
    localparam logic [SRC_W-1:0] S_FG   = SRC_W'(32);
    localparam logic [SRC_W-1:0] S_K    = SRC_W'(33);
    localparam logic [SRC_W-1:0] S_J    = SRC_W'(34);
    localparam logic [SRC_W-1:0] S_RW   = SRC_W'(35);
    localparam logic [SRC_W-1:0] S_RR   = SRC_W'(36);
    localparam logic [SRC_W-1:0] S_D    = SRC_W'(37);
    localparam logic [SRC_W-1:0] S_G    = SRC_W'(38);
    localparam logic [SRC_W-1:0] S_GF   = SRC_W'(39);
    localparam logic [SRC_W-1:0] S_FC   = SRC_W'(40);
    localparam logic [SRC_W-1:0] S_TURN = SRC_W'(41);
    localparam logic [SRC_W-1:0] S_WL   = SRC_W'(42);
    localparam logic [SRC_W-1:0] S_WR   = SRC_W'(43);
    localparam logic [SRC_W-1:0] S_STEP = SRC_W'(44);

    typedef struct packed {
        logic signed [FLD_W-1:0] force_command;
        logic signed [FLD_W-1:0] turn_accel_ref;
        logic signed [FLD_W-1:0] left_wheel_speed;
        logic signed [FLD_W-1:0] right_wheel_speed;
    } cmd_t;

    typedef struct packed {
        logic signed [FLD_W-1:0] left_current;
        logic signed [FLD_W-1:0] right_current;
        logic signed [FLD_W-1:0] reaction_force;
        logic signed [FLD_W-1:0] left_disturbance;
        logic signed [FLD_W-1:0] right_disturbance;
    } res_t;

    typedef struct packed {
        logic [CFG_W-1:0] force_gain;
        logic [CFG_W-1:0] torque_constant;
        logic [CFG_W-1:0] nominal_inertia;
        logic [CFG_W-1:0] wheel_radius;
        logic [CFG_W-1:0] half_track;
        logic [CFG_W-1:0] wheel_friction;
        logic [CFG_W-1:0] observer_cutoff;
        logic [CFG_W-1:0] force_observer_cutoff;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        force_gain:            31'd32768,
        torque_constant:       31'd28180,
        nominal_inertia:       31'd655,
        wheel_radius:          31'd2163,
        half_track:            31'd5243,
        wheel_friction:        31'd3932,
        observer_cutoff:       31'd32768000,
        force_observer_cutoff: 31'd32768000
    };

    typedef enum logic [2:0] {OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_END} op_t;
    typedef enum logic [1:0] {SH_16, SH_17, SH_32} shsel_t;
    typedef enum logic [1:0] {W_NONE, W_32, W_48, W_63} satw_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_FETCH, ST_EXEC, ST_MUL, ST_RND, ST_MSAT, ST_DIV, ST_DSAT, ST_DONE
    } state_t;

    typedef struct packed {
        op_t              op;
        logic [SRC_W-1:0] dst;
        logic [SRC_W-1:0] srca;
        logic [SRC_W-1:0] srcb;
        shsel_t           sh;
        satw_t            w;
    } instr_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_status_t;

    function automatic instr_t mk(input op_t op, input logic [SRC_W-1:0] dst,
                                  input logic [SRC_W-1:0] a, input logic [SRC_W-1:0] b,
                                  input shsel_t sh, input satw_t w);
        instr_t i;
        i.op   = op;
        i.dst  = dst;
        i.srca = a;
        i.srcb = b;
        i.sh   = sh;
        i.w    = w;
        return i;
    endfunction

    function automatic instr_t ucode(input logic [PC_W-1:0] pc);
        instr_t i;
        unique case (pc)
            6'd0:  i = mk(OP_MUL, R_JG,   S_J,    S_G,    SH_16, W_32);
            6'd1:  i = mk(OP_MUL, R_KS,   S_G,    S_STEP, SH_16, W_63);
            6'd2:  i = mk(OP_MUL, R_KFS,  S_GF,   S_STEP, SH_16, W_63);
            6'd3:  i = mk(OP_MUL, R_P,    R_JG,   S_WL,   SH_16, W_32);
            6'd4:  i = mk(OP_MUL, R_KI,   S_K,    R_CL,   SH_16, W_32);
            6'd5:  i = mk(OP_MUL, R_DW,   S_D,    S_WL,   SH_16, W_32);
            6'd6:  i = mk(OP_SUB, R_DOBL, R_IDL,  R_P,    SH_16, W_32);
            6'd7:  i = mk(OP_ADD, R_T1,   R_KI,   R_P,    SH_16, W_NONE);
            6'd8:  i = mk(OP_SUB, R_T2,   R_T1,   R_IDL,  SH_16, W_NONE);
            6'd9:  i = mk(OP_MUL, R_T2,   R_T2,   R_KS,   SH_32, W_48);
            6'd10: i = mk(OP_ADD, R_IDL,  R_IDL,  R_T2,   SH_16, W_48);
            6'd11: i = mk(OP_SUB, R_RTL,  R_IRL,  R_P,    SH_16, W_32);
            6'd12: i = mk(OP_SUB, R_T2,   R_T1,   R_DW,   SH_16, W_NONE);
            6'd13: i = mk(OP_SUB, R_T2,   R_T2,   R_IRL,  SH_16, W_NONE);
            6'd14: i = mk(OP_MUL, R_T2,   R_T2,   R_KS,   SH_32, W_48);
            6'd15: i = mk(OP_ADD, R_IRL,  R_IRL,  R_T2,   SH_16, W_48);
            6'd16: i = mk(OP_MUL, R_P,    R_JG,   S_WR,   SH_16, W_32);
            6'd17: i = mk(OP_MUL, R_KI,   S_K,    R_CR,   SH_16, W_32);
            6'd18: i = mk(OP_MUL, R_DW,   S_D,    S_WR,   SH_16, W_32);
            6'd19: i = mk(OP_SUB, R_DOBR, R_IDR,  R_P,    SH_16, W_32);
            6'd20: i = mk(OP_ADD, R_T1,   R_KI,   R_P,    SH_16, W_NONE);
            6'd21: i = mk(OP_SUB, R_T2,   R_T1,   R_IDR,  SH_16, W_NONE);
            6'd22: i = mk(OP_MUL, R_T2,   R_T2,   R_KS,   SH_32, W_48);
            6'd23: i = mk(OP_ADD, R_IDR,  R_IDR,  R_T2,   SH_16, W_48);
            6'd24: i = mk(OP_SUB, R_RTR,  R_IRR,  R_P,    SH_16, W_32);
            6'd25: i = mk(OP_SUB, R_T2,   R_T1,   R_DW,   SH_16, W_NONE);
            6'd26: i = mk(OP_SUB, R_T2,   R_T2,   R_IRR,  SH_16, W_NONE);
            6'd27: i = mk(OP_MUL, R_T2,   R_T2,   R_KS,   SH_32, W_48);
            6'd28: i = mk(OP_ADD, R_IRR,  R_IRR,  R_T2,   SH_16, W_48);
            6'd29: i = mk(OP_ADD, R_T1,   S_WL,   S_WR,   SH_16, W_NONE);
            6'd30: i = mk(OP_MUL, R_T1,   S_RW,   R_T1,   SH_17, W_32);
            6'd31: i = mk(OP_MUL, R_M,    S_GF,   R_T1,   SH_16, W_32);
            6'd32: i = mk(OP_SUB, R_FRES, R_IF,   R_M,    SH_16, W_32);
            6'd33: i = mk(OP_ADD, R_T1,   R_RTL,  R_RTR,  SH_16, W_32);
            6'd34: i = mk(OP_DIV, R_RT,   R_T1,   S_RW,   SH_16, W_32);
            6'd35: i = mk(OP_ADD, R_T1,   R_RT,   R_M,    SH_16, W_NONE);
            6'd36: i = mk(OP_SUB, R_T1,   R_T1,   R_IF,   SH_16, W_NONE);
            6'd37: i = mk(OP_MUL, R_T1,   R_T1,   R_KFS,  SH_32, W_48);
            6'd38: i = mk(OP_ADD, R_IF,   R_IF,   R_T1,   SH_16, W_48);
            6'd39: i = mk(OP_SUB, R_T1,   S_FC,   R_FRES, SH_16, W_32);
            6'd40: i = mk(OP_MUL, R_T1,   S_FG,   R_T1,   SH_16, W_32);
            6'd41: i = mk(OP_DIV, R_A,    R_T1,   S_RW,   SH_16, W_32);
            6'd42: i = mk(OP_MUL, R_T1,   S_RR,   S_TURN, SH_16, W_32);
            6'd43: i = mk(OP_DIV, R_B,    R_T1,   S_RW,   SH_16, W_32);
            6'd44: i = mk(OP_SUB, R_T1,   R_A,    R_B,    SH_16, W_32);
            6'd45: i = mk(OP_MUL, R_T1,   S_J,    R_T1,   SH_16, W_32);
            6'd46: i = mk(OP_DIV, R_T1,   R_T1,   S_K,    SH_16, W_32);
            6'd47: i = mk(OP_DIV, R_T2,   R_DOBL, S_K,    SH_16, W_32);
            6'd48: i = mk(OP_ADD, R_CL,   R_T1,   R_T2,   SH_16, W_32);
            6'd49: i = mk(OP_ADD, R_T1,   R_A,    R_B,    SH_16, W_32);
            6'd50: i = mk(OP_MUL, R_T1,   S_J,    R_T1,   SH_16, W_32);
            6'd51: i = mk(OP_DIV, R_T1,   R_T1,   S_K,    SH_16, W_32);
            6'd52: i = mk(OP_DIV, R_T2,   R_DOBR, S_K,    SH_16, W_32);
            6'd53: i = mk(OP_ADD, R_CR,   R_T1,   R_T2,   SH_16, W_32);
            default: i = mk(OP_END, R_T1, R_T1,   R_T1,   SH_16, W_NONE);
        endcase
        return i;
    endfunction

endpackage

`default_nettype wire

[hdl/wfc_core.sv]
// Microcoded datapath with register file, bit-serial multiplier and divider.
`timescale 1ns / 1ps
`default_nettype none

module wfc_core
    import wfc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  cfg_t         cfg,
    input  cmd_t         cmd,
    input  logic         start,
    input  logic         hold,
    output core_status_t status,
    output res_t         result
);

    state_t              state_reg, state_next;
    logic [PC_W-1:0]     pc_reg, pc_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [RF_DEPTH-1:0] valid_reg;
    logic [VAL_W-1:0]    rf_mem [RF_DEPTH];

    cmd_t             cmd_reg;
    res_t             stage_reg;
    logic [VAL_W-1:0] opa_reg, opb_reg, ma_reg, mb_reg, acc_reg, lo_reg;
    logic [CFG_W-1:0] dvs_reg, rem_reg;
    logic             neg_reg, carry_reg;

    instr_t           ins;
    logic [VAL_W-1:0] spec_a, spec_b, sum, alu_res;
    logic [VAL_W:0]   msum, rsum;
    logic [VAL_W-1:0] rnd_val, hi2, rl, lim, mr, mres;
    logic             rh_nz;
    logic [VAL_W-1:0] da_sat, dmag, dq, dres;
    logic [CFG_W:0]   r2, r2_sub;
    logic             ge;
    logic             wr_en;
    logic [VAL_W-1:0] wr_data;
    logic [RF_AW-1:0] wr_addr;

    function automatic logic [VAL_W-1:0] spec(input logic [SRC_W-1:0] s, input cfg_t c,
                                              input cmd_t m);
        logic [VAL_W-1:0] v;
        case (s)
            S_FG:    v = VAL_W'(c.force_gain);
            S_K:     v = VAL_W'(c.torque_constant);
            S_J:     v = VAL_W'(c.nominal_inertia);
            S_RW:    v = VAL_W'(c.wheel_radius);
            S_RR:    v = VAL_W'(c.half_track);
            S_D:     v = VAL_W'(c.wheel_friction);
            S_G:     v = VAL_W'(c.observer_cutoff);
            S_GF:    v = VAL_W'(c.force_observer_cutoff);
            S_FC:    v = {{(VAL_W-FLD_W){m.force_command[FLD_W-1]}}, m.force_command};
            S_TURN:  v = {{(VAL_W-FLD_W){m.turn_accel_ref[FLD_W-1]}}, m.turn_accel_ref};
            S_WL:    v = {{(VAL_W-FLD_W){m.left_wheel_speed[FLD_W-1]}}, m.left_wheel_speed};
            S_WR:    v = {{(VAL_W-FLD_W){m.right_wheel_speed[FLD_W-1]}}, m.right_wheel_speed};
            S_STEP:  v = STEP_Q32;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic [VAL_W-1:0] mag(input logic [VAL_W-1:0] v);
        return v[VAL_W-1] ? (~v + VAL_W'(1)) : v;
    endfunction

    function automatic logic [VAL_W-1:0] sat48(input logic [VAL_W-1:0] v);
        logic [VAL_W-1:0] r;
        if (&v[VAL_W-1:47] || ~|v[VAL_W-1:47])
            r = v;
        else
            r = v[VAL_W-1] ? ~((VAL_W'(1) << 47) - VAL_W'(1)) : (VAL_W'(1) << 47) - VAL_W'(1);
        return r;
    endfunction

    // Datapath arithmetic
    always_comb
    begin
        ins    = ucode(pc_reg);
        spec_a = spec(ins.srca, cfg, cmd_reg);
        spec_b = spec(ins.srcb, cfg, cmd_reg);

        sum = (ins.op == OP_SUB) ? opa_reg - opb_reg : opa_reg + opb_reg;
        case (ins.w)
            W_32:
                if (&sum[VAL_W-1:31] || ~|sum[VAL_W-1:31])
                    alu_res = sum;
                else
                    alu_res = sum[VAL_W-1] ? ~((VAL_W'(1) << 31) - VAL_W'(1))
                                           : (VAL_W'(1) << 31) - VAL_W'(1);
            W_48:    alu_res = sat48(sum);
            default: alu_res = sum;
        endcase

        msum = {1'b0, acc_reg} + (mb_reg[0] ? {1'b0, ma_reg} : '0);

        case (ins.sh)
            SH_17:   rnd_val = VAL_W'(1) << 16;
            SH_32:   rnd_val = VAL_W'(1) << 31;
            default: rnd_val = VAL_W'(1) << 15;
        endcase
        rsum = {1'b0, lo_reg} + {1'b0, rnd_val};

        hi2 = acc_reg + VAL_W'(carry_reg);
        case (ins.sh)
            SH_17:
            begin
                rl    = {hi2[16:0], lo_reg[VAL_W-1:17]};
                rh_nz = |hi2[VAL_W-1:17];
            end
            SH_32:
            begin
                rl    = {hi2[31:0], lo_reg[VAL_W-1:32]};
                rh_nz = |hi2[VAL_W-1:32];
            end
            default:
            begin
                rl    = {hi2[15:0], lo_reg[VAL_W-1:16]};
                rh_nz = |hi2[VAL_W-1:16];
            end
        endcase
        case (ins.w)
            W_48:    lim = (VAL_W'(1) << 47) - VAL_W'(!neg_reg);
            W_63:    lim = (VAL_W'(1) << 62) - VAL_W'(!neg_reg);
            default: lim = (VAL_W'(1) << 31) - VAL_W'(!neg_reg);
        endcase
        mr   = (rh_nz || rl > lim) ? lim : rl;
        mres = neg_reg ? (~mr + VAL_W'(1)) : mr;

        da_sat = sat48(opa_reg);
        dmag   = mag(da_sat);
        r2     = {rem_reg, lo_reg[VAL_W-1]};
        ge     = (r2 >= {1'b0, dvs_reg});
        r2_sub = r2 - {1'b0, dvs_reg};
        dq     = (lo_reg > (VAL_W'(1) << 31) - VAL_W'(!neg_reg))
               ? (VAL_W'(1) << 31) - VAL_W'(!neg_reg) : lo_reg;
        if (dvs_reg == '0)
            dres = '0;
        else
            dres = neg_reg ? (~dq + VAL_W'(1)) : dq;

        wr_addr = ins.dst[RF_AW-1:0];
        wr_en   = 1'b0;
        wr_data = alu_res;
        if (state_reg == ST_EXEC && (ins.op == OP_ADD || ins.op == OP_SUB))
            wr_en = 1'b1;
        if (state_reg == ST_MSAT)
        begin
            wr_en   = 1'b1;
            wr_data = mres;
        end
        if (state_reg == ST_DSAT)
        begin
            wr_en   = 1'b1;
            wr_data = dres;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        pc_next     = pc_reg;
        cnt_next    = cnt_reg;
        status.busy = (state_reg != ST_IDLE);
        status.done = 1'b0;
        unique case (state_reg) inside
            ST_IDLE:
                if (start)
                begin
                    pc_next    = '0;
                    state_next = ST_FETCH;
                end
            ST_FETCH:
                state_next = ST_EXEC;
            ST_EXEC:
            begin
                cnt_next = '0;
                case (ins.op) inside
                    OP_ADD, OP_SUB:
                    begin
                        pc_next    = pc_reg + PC_W'(1);
                        state_next = ST_FETCH;
                    end
                    OP_MUL:  state_next = ST_MUL;
                    OP_DIV:  state_next = ST_DIV;
                    default: state_next = ST_DONE;
                endcase
            end
            ST_MUL:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    state_next = ST_RND;
            end
            ST_RND:
                state_next = ST_MSAT;
            ST_DIV:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(MUL_STEPS - 1))
                    state_next = ST_DSAT;
            end
            ST_MSAT, ST_DSAT:
            begin
                pc_next    = pc_reg + PC_W'(1);
                state_next = ST_FETCH;
            end
            ST_DONE:
                if (!hold)
                begin
                    status.done = 1'b1;
                    state_next  = ST_IDLE;
                end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            cnt_reg   <= '0;
            valid_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            cnt_reg   <= cnt_next;
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
            cmd_reg <= cmd;

        if (state_reg == ST_FETCH)
        begin
            if (ins.srca[SRC_W-1])
                opa_reg <= spec_a;
            else if (valid_reg[ins.srca[RF_AW-1:0]])
                opa_reg <= rf_mem[ins.srca[RF_AW-1:0]];
            else
                opa_reg <= '0;
            if (ins.srcb[SRC_W-1])
                opb_reg <= spec_b;
            else if (valid_reg[ins.srcb[RF_AW-1:0]])
                opb_reg <= rf_mem[ins.srcb[RF_AW-1:0]];
            else
                opb_reg <= '0;
        end

        case (state_reg)
            ST_EXEC:
                if (ins.op == OP_MUL)
                begin
                    ma_reg  <= mag(opa_reg);
                    mb_reg  <= mag(opb_reg);
                    acc_reg <= '0;
                    neg_reg <= opa_reg[VAL_W-1] ^ opb_reg[VAL_W-1];
                end
                else if (ins.op == OP_DIV)
                begin
                    lo_reg  <= {dmag[47:0], 16'd0};
                    rem_reg <= '0;
                    dvs_reg <= opb_reg[CFG_W-1:0];
                    neg_reg <= opa_reg[VAL_W-1];
                end
            ST_MUL:
            begin
                acc_reg <= msum[VAL_W:1];
                lo_reg  <= {msum[0], lo_reg[VAL_W-1:1]};
                mb_reg  <= {1'b0, mb_reg[VAL_W-1:1]};
            end
            ST_RND:
            begin
                lo_reg    <= rsum[VAL_W-1:0];
                carry_reg <= rsum[VAL_W];
            end
            ST_DIV:
            begin
                rem_reg <= ge ? r2_sub[CFG_W-1:0] : r2[CFG_W-1:0];
                lo_reg  <= {lo_reg[VAL_W-2:0], ge};
            end
            default: ;
        endcase

        if (wr_en)
        begin
            rf_mem[wr_addr] <= wr_data;
            if (ins.dst == R_CL)
                stage_reg.left_current <= wr_data[FLD_W-1:0];
            if (ins.dst == R_CR)
                stage_reg.right_current <= wr_data[FLD_W-1:0];
            if (ins.dst == R_FRES)
                stage_reg.reaction_force <= wr_data[FLD_W-1:0];
            if (ins.dst == R_DOBL)
                stage_reg.left_disturbance <= wr_data[FLD_W-1:0];
            if (ins.dst == R_DOBR)
                stage_reg.right_disturbance <= wr_data[FLD_W-1:0];
        end
    end

    assign result = stage_reg;

endmodule

`default_nettype wire

[hdl/wheel_force_control_with_observers_top.sv]
// Wheel force controller top level: register port, command and result channels.
//
// Use: write the eight 31-bit unsigned Q15.16 parameter registers over the APB port
// (byte address 4*i) while the block is idle; reads return the stored value.
// Each command transfer (cmd_valid high, cmd_stall low) carries one control
// tick: force command, turn acceleration reference and both wheel speeds.
// The block updates its observers, computes new wheel currents and presents
// one result transfer on res with the currents, reaction force and both
// disturbance estimates.
// The work is set by a microcode of 55 steps on one shared bit-serial
// multiplier (20 products) and one bit-serial divider (7 quotients). One
// tick is worked on at a time; cmd_stall stays high from acceptance until
// the result is loaded into the output register.
// A result waiting under res_stall holds in the output register; the next
// tick may be accepted meanwhile, and its result waits in the core until
// the output register frees.
// Reset clears the observer integrals and stored currents and restores the
// parameter registers to their defaults.
`timescale 1ns / 1ps
`default_nettype none

module wheel_force_control_with_observers_top
    import wfc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    input  cmd_t              cmd,
    output logic              res_valid,
    input  logic              res_stall,
    output res_t              res
);

    cfg_t         cfg_reg;
    logic         res_valid_reg;
    res_t         res_reg;
    core_status_t status;
    res_t         core_res;
    logic         start;
    logic         hold;

    assign pready    = 1'b1;
    assign cmd_stall = status.busy;
    assign start     = cmd_valid && !cmd_stall;
    assign hold      = res_valid_reg && res_stall;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET;
        end
        else if (psel && penable && pwrite && pready)
        begin
            unique case (paddr[APB_AW-1:2])
                REG_FORCE_GAIN:     cfg_reg.force_gain            <= pwdata[CFG_W-1:0];
                REG_TORQUE_CONST:   cfg_reg.torque_constant       <= pwdata[CFG_W-1:0];
                REG_NOM_INERTIA:    cfg_reg.nominal_inertia       <= pwdata[CFG_W-1:0];
                REG_WHEEL_RADIUS:   cfg_reg.wheel_radius          <= pwdata[CFG_W-1:0];
                REG_HALF_TRACK:     cfg_reg.half_track            <= pwdata[CFG_W-1:0];
                REG_WHEEL_FRICTION: cfg_reg.wheel_friction        <= pwdata[CFG_W-1:0];
                REG_OBS_CUTOFF:     cfg_reg.observer_cutoff       <= pwdata[CFG_W-1:0];
                REG_FOBS_CUTOFF:    cfg_reg.force_observer_cutoff <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[APB_AW-1:2])
            REG_FORCE_GAIN:     prdata = {1'b0, cfg_reg.force_gain};
            REG_TORQUE_CONST:   prdata = {1'b0, cfg_reg.torque_constant};
            REG_NOM_INERTIA:    prdata = {1'b0, cfg_reg.nominal_inertia};
            REG_WHEEL_RADIUS:   prdata = {1'b0, cfg_reg.wheel_radius};
            REG_HALF_TRACK:     prdata = {1'b0, cfg_reg.half_track};
            REG_WHEEL_FRICTION: prdata = {1'b0, cfg_reg.wheel_friction};
            REG_OBS_CUTOFF:     prdata = {1'b0, cfg_reg.observer_cutoff};
            REG_FOBS_CUTOFF:    prdata = {1'b0, cfg_reg.force_observer_cutoff};
            default:            prdata = '0;
        endcase
    end

    wfc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .cmd    (cmd),
        .start  (start),
        .hold   (hold),
        .status (status),
        .result (core_res)
    );

    // Hold the result until the transfer completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (status.done)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (status.done)
            res_reg <= core_res;
    end

endmodule

`default_nettype wire

[hdl/wfc_checker.sv]
// Port-level checker for the wheel force controller, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module wfc_checker
    import wfc_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              psel,
    input logic              penable,
    input logic              pwrite,
    input logic [APB_AW-1:0] paddr,
    input logic [31:0]       pwdata,
    input logic [31:0]       prdata,
    input logic              pready,
    input logic              cmd_valid,
    input logic              cmd_stall,
    input logic              res_valid,
    input logic              res_stall,
    input res_t              res
);

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed while stalled");

    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> cmd_stall)
        else $error("second command taken while a tick is in progress");

    a_no_early_res: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> !$rose(res_valid))
        else $error("result appeared right after a command transfer");

    a_cfg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && pready |=>
            (paddr != $past(paddr)) || (prdata == {1'b0, $past(pwdata[30:0])}))
        else $error("register read does not return the written value");

endmodule

bind wheel_force_control_with_observers_top wfc_checker u_wfc_checker (.*);

`default_nettype wire
